FILE: src/adam_linear_regression_fit_defines.svh
// ----------------------------------------------------------------------------
// Adam linear regression fit - assertion macros
// Shared concurrent assertion forms for the fit block.
// ----------------------------------------------------------------------------
`ifndef ADAM_LINEAR_REGRESSION_FIT_DEFINES_SVH
`define ADAM_LINEAR_REGRESSION_FIT_DEFINES_SVH

// same-cycle implication
`define ALRF_ASSERT_HOLD(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ALRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/alrf_pkg.sv
// ----------------------------------------------------------------------------
// alrf_pkg
// Types, constants and saturating Q32.32 helpers for the Adam fit block.
// ----------------------------------------------------------------------------
package alrf_pkg;

	localparam int ALRF_MAX_SAMPLES = 1024;

	localparam logic signed [63:0] Q_ONE   = 64'sh0000_0001_0000_0000;
	localparam logic signed [63:0] EPS_Q   = 64'sd43;
	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	localparam logic [15:0] ITER_RST = 16'd1000;
	localparam logic [32:0] STEP_RST = 33'd429496730;
	localparam logic [31:0] B1_RST   = 32'd3865470566;
	localparam logic [31:0] B2_RST   = 32'd4290672329;

	typedef enum logic [2:0] {
		CFG_ITER      = 3'd0,
		CFG_STEP      = 3'd1,
		CFG_B1        = 3'd2,
		CFG_B2        = 3'd3,
		CFG_INTERCEPT = 3'd4,
		CFG_SLOPE     = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic signed [63:0] feature_value;
		logic signed [63:0] target_value;
		logic               final_sample;
	} sample_t;

	typedef struct packed {
		logic signed [63:0] fitted_intercept;
		logic signed [63:0] fitted_slope;
		logic               samples_dropped;
	} fit_t;

	function automatic logic [63:0] magn(input logic signed [63:0] a);
		logic [63:0] u;
		u = a;
		return a[63] ? (~u + 64'd1) : u;
	endfunction

	function automatic logic signed [63:0] from_magn(input logic neg, input logic [63:0] m);
		if (neg) begin
			return m[63] ? S64_MIN : $signed(~m + 64'd1);
		end
		return m[63] ? S64_MAX : $signed(m);
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? S64_MIN : S64_MAX;
		end
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? S64_MIN : S64_MAX;
		end
		return s[63:0];
	endfunction

endpackage

FILE: src/adam_linear_regression_fit.sv
// ----------------------------------------------------------------------------
// adam_linear_regression_fit
// Stores (x, y) samples and fits y = intercept + slope*x with Adam.
// ----------------------------------------------------------------------------
// Samples load at one per cycle while sample_ready is high into two
// MAX_SAMPLES-deep memories; extra samples are dropped and flagged. A sample
// with final_sample set starts the fit and sample_ready stays low until the
// result has gone to the output register. The fit runs every operation on one
// shared multiplier, one bit-serial divider and one bit-serial square root, so
// an iteration over N stored samples is dominated by two multiplies per sample
// on the gradient pass and eight divides per iteration. Zero iterations or zero
// stored samples return the start values.
// ----------------------------------------------------------------------------
`include "adam_linear_regression_fit_defines.svh"

module adam_linear_regression_fit import alrf_pkg::*; #(
	parameter int MAX_SAMPLES = ALRF_MAX_SAMPLES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_ready,
	input  sample_t     sample,
	output logic        fit_valid,
	input  logic        fit_ready,
	output fit_t        fit,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SAMPLES);

	typedef enum logic [19:0] {
		ST_IDLE  = 20'h00001,
		ST_INIT  = 20'h00002,
		ST_RD    = 20'h00004,
		ST_MSLX  = 20'h00008,
		ST_MERRX = 20'h00010,
		ST_DIVG0 = 20'h00020,
		ST_DIVG1 = 20'h00040,
		ST_MP1   = 20'h00080,
		ST_MP2   = 20'h00100,
		ST_MB1M  = 20'h00200,
		ST_MC1G  = 20'h00400,
		ST_MGG   = 20'h00800,
		ST_MC2GG = 20'h01000,
		ST_MB2V  = 20'h02000,
		ST_DIVM  = 20'h04000,
		ST_DIVV  = 20'h08000,
		ST_SQRT  = 20'h10000,
		ST_DIVR  = 20'h20000,
		ST_MUPD  = 20'h40000,
		ST_EMIT  = 20'h80000
	} st_t;

	// configuration
	logic [15:0]        iter_cfg_q;
	logic [32:0]        step_cfg_q;
	logic [31:0]        b1_cfg_q, b2_cfg_q;
	logic signed [63:0] th0_cfg_q, th1_cfg_q;

	// sample store
	logic [63:0] fmem [MAX_SAMPLES];
	logic [63:0] tmem [MAX_SAMPLES];
	logic signed [63:0] x_q, y_q;

	// fit state
	st_t                st_q;
	logic               issued_q;
	logic [CW-1:0]      cnt_q, i_q;
	logic               ovf_q;
	logic [15:0]        iter_q;
	logic               k_q;
	logic signed [63:0] th_q [2];
	logic signed [63:0] m_q [2];
	logic signed [63:0] v_q [2];
	logic signed [63:0] g_q [2];
	logic signed [63:0] p1_q, p2_q, s0_q, s1_q, err_q, t_q;
	logic signed [63:0] mh_q, vh_q, den_q, rate_q;

	// shared units
	logic               mul_start, div_start, sqrt_start, div_mean;
	logic               mul_done, div_done, sqrt_done;
	logic signed [63:0] mul_a, mul_b, div_a, div_b, sqrt_v;
	logic signed [63:0] mul_res, div_res, sqrt_res;
	logic               use_mul, use_div, use_sqrt;

	logic signed [63:0] b1_w, b2_w, c1_w, c2_w, step_w, n_w, err_c;
	logic [CW-1:0]      i_nxt;
	logic [15:0]        iter_nxt;
	logic               smp_xfer;

	assign b1_w     = {32'd0, b1_cfg_q};
	assign b2_w     = {32'd0, b2_cfg_q};
	assign c1_w     = Q_ONE - b1_w;
	assign c2_w     = Q_ONE - b2_w;
	assign step_w   = {31'd0, step_cfg_q};
	assign n_w      = 64'(cnt_q);
	assign err_c    = sat_sub(sat_add(th_q[0], mul_res), y_q);
	assign i_nxt    = i_q + CW'(1);
	assign iter_nxt = iter_q + 16'd1;

	assign sample_ready = (st_q == ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign smp_xfer     = sample_valid && sample_ready;

	always_comb begin
		use_mul  = 1'b0;
		use_div  = 1'b0;
		use_sqrt = 1'b0;
		div_mean = 1'b0;
		mul_a    = th_q[1];
		mul_b    = x_q;
		div_a    = s0_q;
		div_b    = n_w;
		sqrt_v   = vh_q;
		case (st_q)
			ST_MSLX:  begin use_mul = 1'b1; mul_a = th_q[1]; mul_b = x_q; end
			ST_MERRX: begin use_mul = 1'b1; mul_a = err_q; mul_b = x_q; end
			ST_DIVG0: begin use_div = 1'b1; div_mean = 1'b1; div_a = s0_q; div_b = n_w; end
			ST_DIVG1: begin use_div = 1'b1; div_mean = 1'b1; div_a = s1_q; div_b = n_w; end
			ST_MP1:   begin use_mul = 1'b1; mul_a = p1_q; mul_b = b1_w; end
			ST_MP2:   begin use_mul = 1'b1; mul_a = p2_q; mul_b = b2_w; end
			ST_MB1M:  begin use_mul = 1'b1; mul_a = b1_w; mul_b = m_q[k_q]; end
			ST_MC1G:  begin use_mul = 1'b1; mul_a = c1_w; mul_b = g_q[k_q]; end
			ST_MGG:   begin use_mul = 1'b1; mul_a = g_q[k_q]; mul_b = g_q[k_q]; end
			ST_MC2GG: begin use_mul = 1'b1; mul_a = c2_w; mul_b = t_q; end
			ST_MB2V:  begin use_mul = 1'b1; mul_a = b2_w; mul_b = v_q[k_q]; end
			ST_DIVM:  begin use_div = 1'b1; div_a = m_q[k_q]; div_b = Q_ONE - p1_q; end
			ST_DIVV:  begin use_div = 1'b1; div_a = v_q[k_q]; div_b = Q_ONE - p2_q; end
			ST_SQRT:  begin use_sqrt = 1'b1; sqrt_v = vh_q; end
			ST_DIVR:  begin use_div = 1'b1; div_a = step_w; div_b = den_q; end
			ST_MUPD:  begin use_mul = 1'b1; mul_a = rate_q; mul_b = mh_q; end
			default:  begin use_mul = 1'b0; end
		endcase
	end

	assign mul_start  = use_mul && !issued_q;
	assign div_start  = use_div && !issued_q;
	assign sqrt_start = use_sqrt && !issued_q;

	alrf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.res    (mul_res)
	);

	alrf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mean   (div_mean),
		.a      (div_a),
		.b      (div_b),
		.done   (div_done),
		.res    (div_res)
	);

	alrf_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.v      (sqrt_v),
		.done   (sqrt_done),
		.res    (sqrt_res)
	);

	// sample memories, registered read
	always_ff @(posedge clk) begin
		if (smp_xfer && (cnt_q < CNT_MAX)) begin
			fmem[cnt_q[AW-1:0]] <= sample.feature_value;
			tmem[cnt_q[AW-1:0]] <= sample.target_value;
		end
		if (st_q == ST_RD) begin
			x_q <= fmem[i_q[AW-1:0]];
			y_q <= tmem[i_q[AW-1:0]];
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_cfg_q <= ITER_RST;
			step_cfg_q <= STEP_RST;
			b1_cfg_q   <= B1_RST;
			b2_cfg_q   <= B2_RST;
			th0_cfg_q  <= '0;
			th1_cfg_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ITER:      iter_cfg_q <= cfg_data[15:0];
				CFG_STEP:      step_cfg_q <= cfg_data[32:0];
				CFG_B1:        b1_cfg_q   <= cfg_data[31:0];
				CFG_B2:        b2_cfg_q   <= cfg_data[31:0];
				CFG_INTERCEPT: th0_cfg_q  <= cfg_data;
				CFG_SLOPE:     th1_cfg_q  <= cfg_data;
				default:       iter_cfg_q <= iter_cfg_q;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if ((st_q == ST_EMIT) && (!fit_valid || fit_ready)) begin
			fit.fitted_intercept <= th_q[0];
			fit.fitted_slope     <= th_q[1];
			fit.samples_dropped  <= ovf_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			issued_q  <= 1'b0;
			cnt_q     <= '0;
			i_q       <= '0;
			ovf_q     <= 1'b0;
			iter_q    <= '0;
			k_q       <= 1'b0;
			fit_valid <= 1'b0;
			th_q[0]   <= '0;
			th_q[1]   <= '0;
			m_q[0]    <= '0;
			m_q[1]    <= '0;
			v_q[0]    <= '0;
			v_q[1]    <= '0;
			g_q[0]    <= '0;
			g_q[1]    <= '0;
			p1_q      <= Q_ONE;
			p2_q      <= Q_ONE;
			s0_q      <= '0;
			s1_q      <= '0;
			err_q     <= '0;
			t_q       <= '0;
			mh_q      <= '0;
			vh_q      <= '0;
			den_q     <= '0;
			rate_q    <= '0;
		end else begin
			// the emit step sets valid itself when it loads a new result
			if (fit_valid && fit_ready && (st_q != ST_EMIT)) begin
				fit_valid <= 1'b0;
			end
			if (mul_start || div_start || sqrt_start) begin
				issued_q <= 1'b1;
			end
			if (mul_done || div_done || sqrt_done) begin
				issued_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (smp_xfer) begin
						if (cnt_q < CNT_MAX) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (sample.final_sample) begin
							st_q <= ST_INIT;
						end
					end
				end
				ST_INIT: begin
					th_q[0] <= th0_cfg_q;
					th_q[1] <= th1_cfg_q;
					m_q[0]  <= '0;
					m_q[1]  <= '0;
					v_q[0]  <= '0;
					v_q[1]  <= '0;
					p1_q    <= Q_ONE;
					p2_q    <= Q_ONE;
					iter_q  <= '0;
					i_q     <= '0;
					s0_q    <= '0;
					s1_q    <= '0;
					st_q    <= ((cnt_q == '0) || (iter_cfg_q == 16'd0)) ? ST_EMIT : ST_RD;
				end
				ST_RD: st_q <= ST_MSLX;
				ST_MSLX: begin
					if (mul_done) begin
						err_q <= err_c;
						s0_q  <= sat_add(s0_q, err_c);
						st_q  <= ST_MERRX;
					end
				end
				ST_MERRX: begin
					if (mul_done) begin
						s1_q <= sat_add(s1_q, mul_res);
						i_q  <= i_nxt;
						st_q <= (i_nxt == cnt_q) ? ST_DIVG0 : ST_RD;
					end
				end
				ST_DIVG0: if (div_done) begin g_q[0] <= div_res; st_q <= ST_DIVG1; end
				ST_DIVG1: if (div_done) begin g_q[1] <= div_res; st_q <= ST_MP1; end
				ST_MP1:   if (mul_done) begin p1_q <= mul_res; st_q <= ST_MP2; end
				ST_MP2: begin
					if (mul_done) begin
						p2_q <= mul_res;
						k_q  <= 1'b0;
						st_q <= ST_MB1M;
					end
				end
				ST_MB1M: if (mul_done) begin t_q <= mul_res; st_q <= ST_MC1G; end
				ST_MC1G: begin
					if (mul_done) begin
						m_q[k_q] <= sat_add(t_q, mul_res);
						st_q     <= ST_MGG;
					end
				end
				ST_MGG:   if (mul_done) begin t_q <= mul_res; st_q <= ST_MC2GG; end
				ST_MC2GG: if (mul_done) begin t_q <= mul_res; st_q <= ST_MB2V; end
				ST_MB2V: begin
					if (mul_done) begin
						v_q[k_q] <= sat_add(mul_res, t_q);
						st_q     <= ST_DIVM;
					end
				end
				ST_DIVM: if (div_done) begin mh_q <= div_res; st_q <= ST_DIVV; end
				ST_DIVV: if (div_done) begin vh_q <= div_res; st_q <= ST_SQRT; end
				ST_SQRT: begin
					if (sqrt_done) begin
						den_q <= sqrt_res + EPS_Q;
						st_q  <= ST_DIVR;
					end
				end
				ST_DIVR: if (div_done) begin rate_q <= div_res; st_q <= ST_MUPD; end
				ST_MUPD: begin
					if (mul_done) begin
						th_q[k_q] <= sat_sub(th_q[k_q], mul_res);
						if (!k_q) begin
							k_q  <= 1'b1;
							st_q <= ST_MB1M;
						end else begin
							iter_q <= iter_nxt;
							i_q    <= '0;
							s0_q   <= '0;
							s1_q   <= '0;
							st_q   <= (iter_nxt == iter_cfg_q) ? ST_EMIT : ST_RD;
						end
					end
				end
				ST_EMIT: begin
					if (!fit_valid || fit_ready) begin
						fit_valid <= 1'b1;
						cnt_q     <= '0;
						ovf_q     <= 1'b0;
						st_q      <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`ALRF_ASSERT_NEXT(a_final_blocks, clk, arst_n, smp_xfer && sample.final_sample, !sample_ready, "sample transfer right after a final sample")
	`ALRF_ASSERT_HOLD(a_one_unit, clk, arst_n, 1'b1, $onehot0({mul_start, div_start, sqrt_start}), "two shared units started at once")
	`ALRF_ASSERT_HOLD(a_done_issued, clk, arst_n, mul_done || div_done || sqrt_done, issued_q, "unit finished without an issued operation")
	`ALRF_ASSERT_HOLD(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CNT_MAX, "sample count beyond store depth")
	`ALRF_ASSERT_HOLD(a_emit_idle, clk, arst_n, $rose(fit_valid), st_q == ST_IDLE, "result raised outside the emit step")

endmodule

FILE: src/alrf_mul.sv
// ----------------------------------------------------------------------------
// alrf_mul
// Q32.32 signed multiplier: four 32x32 partial products, round, saturate.
// ----------------------------------------------------------------------------
module alrf_mul import alrf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic               done,
	output logic signed [63:0] res
);

	typedef enum logic [2:0] {
		MUL_IDLE = 3'b001,
		MUL_ACC  = 3'b010,
		MUL_FIN  = 3'b100
	} mul_st_t;

	mul_st_t      st_q;
	logic [63:0]  am_q, bm_q;
	logic         neg_q;
	logic [127:0] acc_q;
	logic [1:0]   ph_q;

	logic [31:0]  a_half, b_half;
	logic [63:0]  pp;
	logic [6:0]   sh;
	logic [127:0] pp_sh, rnd;
	logic [63:0]  mmag;

	assign a_half = ph_q[1] ? am_q[63:32] : am_q[31:0];
	assign b_half = ph_q[0] ? bm_q[63:32] : bm_q[31:0];
	assign pp     = a_half * b_half;
	// weight: lo*lo 0, cross terms 32, hi*hi 64
	assign sh     = {ph_q[1] & ph_q[0], ph_q[1] ^ ph_q[0], 5'd0};
	assign pp_sh  = {64'd0, pp} << sh;
	assign rnd    = acc_q + 128'h8000_0000;
	assign mmag   = (|rnd[127:96]) ? '1 : rnd[95:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= MUL_IDLE;
			done  <= 1'b0;
			res   <= '0;
			am_q  <= '0;
			bm_q  <= '0;
			neg_q <= 1'b0;
			acc_q <= '0;
			ph_q  <= '0;
		end else begin
			done <= 1'b0;
			case (st_q)
				MUL_IDLE: begin
					if (start) begin
						am_q  <= magn(a);
						bm_q  <= magn(b);
						neg_q <= a[63] ^ b[63];
						acc_q <= '0;
						ph_q  <= '0;
						st_q  <= MUL_ACC;
					end
				end
				MUL_ACC: begin
					acc_q <= acc_q + pp_sh;
					ph_q  <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						st_q <= MUL_FIN;
					end
				end
				MUL_FIN: begin
					res  <= from_magn(neg_q, mmag);
					done <= 1'b1;
					st_q <= MUL_IDLE;
				end
				default: st_q <= MUL_IDLE;
			endcase
		end
	end

endmodule

FILE: src/alrf_div.sv
// ----------------------------------------------------------------------------
// alrf_div
// Restoring divider, one quotient bit per cycle. Q mode divides (a<<32)/b,
// integer mode a/b; truncates toward zero and saturates.
// ----------------------------------------------------------------------------
module alrf_div import alrf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               mean,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic               done,
	output logic signed [63:0] res
);

	typedef enum logic [2:0] {
		DIV_IDLE = 3'b001,
		DIV_RUN  = 3'b010,
		DIV_FIN  = 3'b100
	} div_st_t;

	div_st_t      st_q;
	logic [127:0] dvd_q;
	logic [63:0]  d_q, r_q, q_q;
	logic         ovf_q, neg_q, asgn_q, zero_q, dz_q;
	logic [6:0]   cnt_q;

	logic [63:0]  n_w, d_w, rs, rn;
	logic         ge;

	assign n_w = magn(a);
	assign d_w = magn(b);
	assign rs  = {r_q[62:0], dvd_q[127]};
	assign ge  = r_q[63] | (rs >= d_q);
	assign rn  = ge ? (rs - d_q) : rs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= DIV_IDLE;
			done   <= 1'b0;
			res    <= '0;
			dvd_q  <= '0;
			d_q    <= '0;
			r_q    <= '0;
			q_q    <= '0;
			ovf_q  <= 1'b0;
			neg_q  <= 1'b0;
			asgn_q <= 1'b0;
			zero_q <= 1'b0;
			dz_q   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			case (st_q)
				DIV_IDLE: begin
					if (start) begin
						dvd_q  <= mean ? {64'd0, n_w} : {32'd0, n_w, 32'd0};
						d_q    <= d_w;
						r_q    <= '0;
						q_q    <= '0;
						ovf_q  <= 1'b0;
						neg_q  <= a[63] ^ b[63];
						asgn_q <= a[63];
						zero_q <= (n_w == 64'd0);
						dz_q   <= (d_w == 64'd0);
						cnt_q  <= '0;
						st_q   <= ((n_w == 64'd0) || (d_w == 64'd0)) ? DIV_FIN : DIV_RUN;
					end
				end
				DIV_RUN: begin
					r_q   <= rn;
					dvd_q <= {dvd_q[126:0], 1'b0};
					q_q   <= {q_q[62:0], ge};
					ovf_q <= ovf_q | q_q[63];
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd127) begin
						st_q <= DIV_FIN;
					end
				end
				DIV_FIN: begin
					if (zero_q) begin
						res <= '0;
					end else if (dz_q) begin
						res <= asgn_q ? S64_MIN : S64_MAX;
					end else begin
						res <= from_magn(neg_q, ovf_q ? '1 : q_q);
					end
					done <= 1'b1;
					st_q <= DIV_IDLE;
				end
				default: st_q <= DIV_IDLE;
			endcase
		end
	end

endmodule

FILE: src/alrf_sqrt.sv
// ----------------------------------------------------------------------------
// alrf_sqrt
// Digit-by-digit square root of v<<32, one result bit per cycle.
// ----------------------------------------------------------------------------
module alrf_sqrt import alrf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] v,
	output logic               done,
	output logic signed [63:0] res
);

	typedef enum logic [2:0] {
		SQ_IDLE = 3'b001,
		SQ_RUN  = 3'b010,
		SQ_FIN  = 3'b100
	} sq_st_t;

	sq_st_t      st_q;
	logic [95:0] rad_q;
	logic [49:0] rem_q;
	logic [47:0] root_q;
	logic [5:0]  cnt_q;
	logic        zero_q;

	logic [51:0] rs, trial, diff;
	logic        ge;

	assign rs    = {rem_q, rad_q[95:94]};
	assign trial = {2'd0, root_q, 2'b01};
	assign ge    = (rs >= trial);
	assign diff  = rs - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= SQ_IDLE;
			done   <= 1'b0;
			res    <= '0;
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			zero_q <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				SQ_IDLE: begin
					if (start) begin
						rad_q  <= {v, 32'd0};
						rem_q  <= '0;
						root_q <= '0;
						cnt_q  <= '0;
						// negative or zero operand gives zero
						zero_q <= v[63] || (v == 64'sd0);
						st_q   <= SQ_RUN;
					end
				end
				SQ_RUN: begin
					rem_q  <= ge ? diff[49:0] : rs[49:0];
					root_q <= {root_q[46:0], ge};
					rad_q  <= {rad_q[93:0], 2'b00};
					cnt_q  <= cnt_q + 6'd1;
					if (cnt_q == 6'd47) begin
						st_q <= SQ_FIN;
					end
				end
				SQ_FIN: begin
					res  <= zero_q ? 64'sd0 : $signed({16'd0, root_q});
					done <= 1'b1;
					st_q <= SQ_IDLE;
				end
				default: st_q <= SQ_IDLE;
			endcase
		end
	end

endmodule
